/* rtl/text_console_writer_defines.svh */
// Assertion macros for the text console writer.
// Used by the top level; expects clk and rst in scope where expanded.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("text console writer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("text console writer: next-cycle check failed");

`endif

/* rtl/tcw_pkg.sv */
// Shared types and codes of the text console writer.
// No dependencies; imported by the controller, datapath and top level.
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic cnt_clear;
    logic cnt_inc;
    logic fill;
    logic copy;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_scroll;
    logic start_clear;
    logic cnt_at_row;
    logic cnt_at_end;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/tcw_channels.sv */
// Valid/ready channel interfaces for request and result words.
// No dependencies.
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input operation, input char_code, input cell_index,
                output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [10:0] cursor_position;
  logic        scrolled;

  modport source (output valid, output cell_char, output cursor_position, output scrolled,
                  input ready);
  modport sink (input valid, input cell_char, input cursor_position, input scrolled,
                output ready);
endinterface

/* rtl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tcw_ctrl.sv */
// Controller of the text console writer: sequences the reset fill, accept, scroll, clear and result.
// Depends on tcw_pkg.
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tcw_pkg::sts_t sts,
  output logic          in_ready,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:  if (sts.cnt_at_end) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.start_scroll) begin
            state_next = ST_COPY;
          end else if (sts.start_clear) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_COPY:  if (sts.cnt_at_row) state_next = ST_BLANK;
      ST_BLANK: if (sts.cnt_at_end) state_next = ST_DONE;
      ST_CLEAR: if (sts.cnt_at_end) state_next = ST_DONE;
      ST_DONE:  if (!sts.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_INIT, ST_BLANK, ST_CLEAR: begin
        cmd.fill    = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.cnt_clear = in_valid;
      end
      ST_COPY: begin
        cmd.copy    = 1'b1;
        cmd.cnt_inc = !sts.cnt_at_row;
      end
      ST_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: cursor, sweep counter, screen RAM, result register.
// Depends on tcw_pkg, tcw_channels and tcw_ram.
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  tcw_in_if.sink        request,
  tcw_out_if.source     result,
  input  tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t sts
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [CW-1:0]   LAST_CELL      = CW'(CELLS - 1);
  localparam logic [CW-1:0]   LAST_ROW_START = CW'(COLUMNS * (ROWS - 1));
  localparam logic [CW-1:0]   ROW_STEP       = CW'(COLUMNS);
  localparam logic [RW-1:0]   LAST_ROW       = RW'(ROWS - 1);
  localparam logic [COLW-1:0] LAST_COL       = COLW'(COLUMNS - 1);

  logic [CW-1:0]   cursor;
  logic [RW-1:0]   row;
  logic [COLW-1:0] col;
  logic [CW-1:0]   cnt;
  logic            rd_hit;
  logic            scroll_flag;

  logic            out_valid;
  logic [7:0]      out_char;
  logic [10:0]     out_cursor;
  logic            out_scrolled;

  logic            is_put;
  logic            is_nl;
  logic            wrap_put;
  logic            nl_scroll;
  logic            in_range;
  logic [31:0]     cursor_wide;

  logic            we;
  logic [CW-1:0]   waddr;
  logic [7:0]      wdata;
  logic            re;
  logic [CW-1:0]   raddr;
  logic [7:0]      rdata;

  assign is_put      = (request.operation == OP_PUT);
  assign is_nl       = (request.char_code == NEWLINE_CODE);
  assign wrap_put    = is_put && !is_nl && (cursor == LAST_CELL);
  assign nl_scroll   = is_put && is_nl && (row == LAST_ROW);
  assign in_range    = (32'(request.cell_index) < CELLS);
  assign cursor_wide = 32'(cursor);

  assign sts.start_scroll = wrap_put || nl_scroll;
  assign sts.start_clear  = (request.operation == OP_CLEAR);
  assign sts.cnt_at_row   = (cnt == LAST_ROW_START);
  assign sts.cnt_at_end   = (cnt == LAST_CELL);
  assign sts.out_busy     = out_valid && !result.ready;

  // Screen RAM port selection: store or read on accept, copy one row up, or fill spaces.
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = SPACE_CODE;
    re    = 1'b0;
    raddr = cnt + ROW_STEP;
    if (cmd.accept) begin
      if (is_put && !is_nl) begin
        we    = 1'b1;
        waddr = cursor;
        wdata = request.char_code;
      end
      if (request.operation == OP_READ) begin
        re    = 1'b1;
        raddr = CW'(request.cell_index);
      end
    end
    if (cmd.copy) begin
      re    = (cnt != LAST_ROW_START);
      raddr = cnt + ROW_STEP;
      we    = (cnt != '0);
      waddr = cnt - CW'(1);
      wdata = rdata;
    end
    if (cmd.fill) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = SPACE_CODE;
    end
  end

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
  end

  // Cursor kept both linear and as row/column so newline needs no divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      row    <= '0;
      col    <= '0;
    end else if (cmd.accept) begin
      if (wrap_put || nl_scroll) begin
        cursor <= LAST_ROW_START;
        row    <= LAST_ROW;
        col    <= '0;
      end else if (is_put && is_nl) begin
        cursor <= cursor + ROW_STEP - CW'(col);
        row    <= row + RW'(1);
        col    <= '0;
      end else if (is_put) begin
        cursor <= cursor + CW'(1);
        if (col == LAST_COL) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + COLW'(1);
        end
      end else if (request.operation == OP_CLEAR) begin
        cursor <= '0;
        row    <= '0;
        col    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_hit      <= (request.operation == OP_READ) && in_range;
      scroll_flag <= wrap_put || nl_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_char     <= rd_hit ? rdata : 8'd0;
      out_cursor   <= cursor_wide[10:0];
      out_scrolled <= scroll_flag;
    end
  end

  assign result.valid           = out_valid;
  assign result.cell_char       = out_char;
  assign result.cursor_position = out_cursor;
  assign result.scrolled        = out_scrolled;

endmodule

/* rtl/text_console_writer.sv */
// Top level of the text console writer: character-cell screen with a linear cursor.
// Depends on tcw_pkg, tcw_channels, tcw_ctrl, tcw_datapath and the defines header.
//
// Usage:
//   request carries one word per operation: put character (newline moves the
//   cursor to the next row), clear screen, or read one cell. result returns
//   exactly one word per request: the cell read (zero otherwise), the cursor
//   position after the operation and a flag set when the screen scrolled.
// Sequencing:
//   Put, newline without scroll, read and unused codes go through accept,
//   then load of the result register. A scroll copies COLUMNS*(ROWS-1) cells
//   one per cycle through the screen RAM port plus a drain step, then
//   blanks COLUMNS cells, between accept and load. A clear writes one cell
//   per cycle between accept and load. The single RAM write port sets
//   these rates.
// Reset:
//   rst is synchronous, active high. Afterward the block fills the screen
//   with spaces, one cell per cycle (COLUMNS*ROWS cells, 2000 by default),
//   and keeps request.ready low until done. The cursor starts at cell 0.
// Stalls:
//   The result register holds its word while result.ready is low; the next
//   request is still accepted and processed, and waits only for that slot.
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic       clk,
  input logic       rst,
  tcw_in_if.sink    request,
  tcw_out_if.source result
);
  import tcw_pkg::*;

  localparam int          CELLS        = COLUMNS * ROWS;
  localparam logic [10:0] LAST_ROW_POS = 11'(COLUMNS * (ROWS - 1));

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Ready comes from the controller only: high in its idle state.
  assign request.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .sts     (sts)
  );

  // An accepted word blocks the next one: request.ready drops after each accept.
  `TCW_ASSERT_NEXT(a_accept_blocks, request.valid && request.ready, !request.ready)
  // A scroll always leaves the cursor at the start of the bottom row.
  `TCW_ASSERT_NOW(a_scroll_cursor, result.valid && result.scrolled, result.cursor_position == LAST_ROW_POS)
  // The reported cursor never leaves the screen.
  `TCW_ASSERT_NOW(a_cursor_range, result.valid, 32'(result.cursor_position) < CELLS)

endmodule

/* tb/sv/tcw_screen_checker.sv */
`timescale 1ns / 1ps
// Screen checker for the text console writer testbench: keeps its own screen
// and cursor, predicts one result word per request word and compares them.
// Depends on tcw_pkg and the tcw_in_if / tcw_out_if channel interfaces.
module tcw_screen_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst,
  tcw_in_if    request,
  tcw_out_if   result,
  output int   mismatch_count,
  output int   words_in_flight
);
  import tcw_pkg::*;

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [10:0] cursor_position;
    logic        scrolled;
  } console_word_t;

  logic [7:0]    screen [CELLS];
  logic [10:0]   cursor;
  console_word_t due_words [$];
  int            results_seen;

  initial begin
    mismatch_count  = 0;
    words_in_flight = 0;
    results_seen    = 0;
  end

  // Move every row up by one, blank the bottom row, park the cursor there.
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = SPACE_CODE;
    cursor = 11'(CELLS - COLUMNS);
  endfunction

  function automatic console_word_t advance_console(logic [1:0] op, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_word_t w;
    int            row;
    w = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          row = int'(cursor) / COLUMNS;
          if (row + 1 >= ROWS) begin
            scroll_screen();
            w.scrolled = 1'b1;
          end else begin
            cursor = 11'((row + 1) * COLUMNS);
          end
        end else begin
          screen[cursor] = ch;
          cursor = cursor + 11'd1;
          if (int'(cursor) >= CELLS) begin
            scroll_screen();
            w.scrolled = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = SPACE_CODE;
        cursor = '0;
      end
      OP_READ: begin
        if (int'(idx) < CELLS) w.cell_char = screen[idx];
      end
      default: ;
    endcase
    w.cursor_position = cursor;
    return w;
  endfunction

  function automatic void note_failure(string what);
    if (mismatch_count < MAX_REPORTS) $display("%t checker: %s", $realtime, what);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    console_word_t want;
    console_word_t got;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = SPACE_CODE;
      cursor = '0;
      due_words.delete();
    end else begin
      // Retire the oldest prediction first; a new request in the same cycle
      // can never own this result.
      if (result.valid && result.ready) begin
        got = '{result.cell_char, result.cursor_position, result.scrolled};
        if (due_words.size() == 0) begin
          note_failure($sformatf("result %0d with nothing outstanding: char %h cursor %0d scroll %b",
                                 results_seen, got.cell_char, got.cursor_position,
                                 got.scrolled));
        end else begin
          want = due_words.pop_front();
          if (got !== want)
            note_failure($sformatf({"result %0d: expected char %h cursor %0d scroll %b, ",
                                    "got char %h cursor %0d scroll %b"},
                                   results_seen, want.cell_char, want.cursor_position,
                                   want.scrolled, got.cell_char, got.cursor_position,
                                   got.scrolled));
        end
        results_seen++;
      end
      if (request.valid && request.ready)
        due_words.push_back(advance_console(request.operation, request.char_code,
                                            request.cell_index));
    end
    words_in_flight = due_words.size();
  end

endmodule

/* tb/sv/text_console_writer_tb.sv */
`timescale 1ns / 1ps
// Top of the text console writer testbench: clock, reset, request stimulus
// and result back-pressure; checking lives in tcw_screen_checker.
// Depends on tcw_pkg, the channel interfaces, the block and the checker.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Operation code the block must treat as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Roughly how many request words the run sends.
  localparam int TARGET_WORDS = 1350;

  // Longest quiet stretch of a correct run is a scroll or clear on top of a
  // full receiver stall and sender gap, or the clearing pass after reset.
  // Allow ten times that.
  localparam int QUIET_LIMIT = 10 * (CELLS + 32);

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcw_in_if  request ();
  tcw_out_if result ();

  int mismatch_count;
  int words_in_flight;
  int words_sent;
  int quiet_cycles;
  bit idle_on;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .result (result)
  );

  tcw_screen_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) screen_check (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .result         (result),
    .mismatch_count (mismatch_count),
    .words_in_flight(words_in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one request word and hold it until the block takes it.
  // Entered and left at a falling edge, so valid stays high across
  // back-to-back words and is only dropped for a real gap.
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      request.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request.valid      = 1'b1;
    request.operation  = op;
    request.char_code  = ch;
    request.cell_index = idx;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    request.valid = 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  // Any byte but newline, so a text line ends only where intended.
  function automatic logic [7:0] random_glyph();
    logic [7:0] g;
    g = 8'($urandom_range(0, 255));
    if (g == NEWLINE_CODE) g = 8'h7E;
    return g;
  endfunction

  // Lean reads toward the bottom rows, where text piles up after scrolling,
  // and keep some beyond the screen to exercise the out-of-range case.
  function automatic logic [10:0] random_cell();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 11'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
    if (pick < 85) return 11'($urandom_range(0, CELLS - 1));
    return 11'($urandom_range(CELLS, 2047));
  endfunction

  function automatic logic [10:0] random_index();
    return 11'($urandom_range(0, 2047));
  endfunction

  // Result side: stall a random number of cycles, then take one word.
  initial begin
    int stall;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        result.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result.ready = 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int pick;
    int len;
    int next_mode_change;

    request.valid      = 1'b0;
    request.operation  = OP_PUT;
    request.char_code  = '0;
    request.cell_index = '0;
    words_sent         = 0;
    quiet_cycles       = 0;
    idle_on            = 1'b1;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: reads at the screen edges and beyond, the unused code,
    // extreme character bytes, newline, clear and reads of what was written.
    send_word(OP_READ,   8'hFF,        11'd0);
    send_word(OP_READ,   8'h00,        11'(CELLS - 1));
    send_word(OP_READ,   8'h00,        11'(CELLS));
    send_word(OP_READ,   8'h00,        11'h7FF);
    send_word(OP_UNUSED, 8'hFF,        11'h7FF);
    send_word(OP_PUT,    8'h00,        11'h7FF);
    send_word(OP_PUT,    8'hFF,        11'd0);
    send_word(OP_PUT,    8'h41,        11'd0);
    send_word(OP_PUT,    NEWLINE_CODE, 11'd0);
    send_word(OP_PUT,    8'h7E,        11'd0);
    send_word(OP_READ,   8'h00,        11'd0);
    send_word(OP_READ,   8'h00,        11'd1);
    send_word(OP_READ,   8'h00,        11'd2);
    send_word(OP_READ,   8'h00,        11'(COLUMNS));
    send_word(OP_UNUSED, 8'h00,        11'd0);
    send_word(OP_PUT,    NEWLINE_CODE, 11'd0);
    send_word(OP_CLEAR,  8'hFF,        11'h7FF);
    send_word(OP_READ,   8'h00,        11'd0);
    send_word(OP_READ,   8'h00,        11'(COLUMNS));
    send_word(OP_PUT,    NEWLINE_CODE, 11'd0);
    send_word(OP_PUT,    8'h55,        11'd0);
    send_word(OP_READ,   8'h00,        11'(COLUMNS));
    drain_results();

    // Random: mostly text lines of random length ending in a newline, so the
    // cursor walks down to the bottom row and newlines start scrolling; some
    // long lines run off the last cell. Reads, clears and raw noise are mixed in.
    next_mode_change = words_sent;
    while (words_sent < TARGET_WORDS) begin
      if (words_sent >= next_mode_change) begin
        idle_on          = ($urandom_range(0, 2) != 0);
        next_mode_change = words_sent + $urandom_range(60, 160);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
        repeat (len) begin
          send_word(OP_PUT, random_glyph(), random_index());
          if ($urandom_range(0, 4) == 0)
            send_word(OP_READ, 8'($urandom_range(0, 255)), random_cell());
        end
        send_word(OP_PUT, NEWLINE_CODE, random_index());
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6))
          send_word(OP_READ, 8'($urandom_range(0, 255)), random_cell());
      end else if (pick < 90) begin
        send_word(OP_CLEAR, 8'($urandom_range(0, 255)), random_index());
      end else if (pick < 97) begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), random_index());
      end else begin
        drain_results();
      end
    end

    // Drop valid, let every result come home, then watch for strays.
    request.valid = 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (CELLS + 16) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* text_console_writer.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_channels.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
tb/sv/tcw_screen_checker.sv
tb/sv/text_console_writer_tb.sv
